>>> hw/rtl/rli2d_pkg.sv
package rli2d_pkg;

  localparam int QW = 32;
  localparam int FRAC = 16;
  localparam int DENW = 50;
  localparam int QUOW = 32;
  localparam int PIPE_DEPTH = 38;
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-1:0] ADDR_NORMAL_X = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_NORMAL_Y = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_ANCHOR_X = 4'h8;
  localparam logic [ADDR_W-1:0] ADDR_ANCHOR_Y = 4'hC;

  localparam logic signed [QW-1:0] NORMAL_X_RST = 32'sh0;
  localparam logic signed [QW-1:0] NORMAL_Y_RST = 32'sh0001_0000;
  localparam logic signed [QW-1:0] ANCHOR_X_RST = 32'sh0;
  localparam logic signed [QW-1:0] ANCHOR_Y_RST = 32'sh0;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = -32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] near_x;
    logic signed [31:0] near_y;
    logic               overflow;
  } result_t;

  // floor(a*b/2^16) of a 96-bit product, truncated to 64 bits
  function automatic logic signed [63:0] qfloor(input logic signed [95:0] p);
    qfloor = 64'(p >>> FRAC);
  endfunction

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) sat32 = Q_MAX;
    else if (v < 64'(Q_MIN)) sat32 = Q_MIN;
    else sat32 = v[QW-1:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    ovf32 = (v > 64'(Q_MAX)) || (v < 64'(Q_MIN));
  endfunction

endpackage

>>> hw/rtl/rli2d_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// q = floor(a*2^16 / b) limited to QUOW bits; sat set when q >= 2^31.
module rli2d_div #(
  parameter int AW = rli2d_pkg::DENW,
  parameter int QB = rli2d_pkg::QUOW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [QB-1:0] q,
  output logic          sat
);
  // Quotient must be < 2^31 when a < b*2^15; test that ahead.
  // stage 0 register: overflow check
  logic [AW-1:0]    a_r, b_r;
  logic             ov_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= a;
      b_r  <= b;
      ov_r <= ({15'h0, a} >= ({b, 15'h0}));
    end
  end

  // long division: remainder from top bits of a*2^16, one bit per stage
  // start with high part (a >> (QB-16)) as partial remainder, then shift in
  logic [AW-1:0]  pr   [QB+1];
  logic [AW-1:0]  pd   [QB+1];
  logic [QB-1:0]  pq   [QB+1];
  logic [AW-1:0]  pa   [QB+1];
  logic           pov  [QB+1];

  always_comb begin
    pr[0]  = AW'({16'h0, a_r} >> (QB - 16));
    pd[0]  = b_r;
    pq[0]  = '0;
    pa[0]  = a_r;
    pov[0] = ov_r;
  end

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [AW:0]   sh;
    logic [AW:0]   df;
    logic [AW-1:0] r_q, d_q, a_q;
    logic [QB-1:0] q_q;
    logic          o_q;
    logic          nb;
    // bit index of (a*2^16) brought in at this step
    if (QB - 1 - i >= 16) begin : g_abit
      assign nb = pa[i][QB - 1 - i - 16];
    end else begin : g_zbit
      assign nb = 1'b0;
    end
    always_comb begin
      sh = {pr[i], nb};
      df = sh - {1'b0, pd[i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        r_q <= df[AW] ? sh[AW-1:0] : df[AW-1:0];
        q_q <= {pq[i][QB-2:0], ~df[AW]};
        d_q <= pd[i];
        a_q <= pa[i];
        o_q <= pov[i];
      end
    end
    assign pr[i+1]  = r_q;
    assign pd[i+1]  = d_q;
    assign pq[i+1]  = q_q;
    assign pa[i+1]  = a_q;
    assign pov[i+1] = o_q;
  end

  assign q   = pq[QB];
  assign sat = pov[QB];

  logic unused;
  assign unused = ^{in_vld, rst, pr[QB], pd[QB], pa[QB]};
endmodule

>>> hw/rtl/ray_line_intersect_2d.sv
// Channel  | Dir | Handshake       | Payload
// ray      | in  | ray_valid/stall | rli2d_pkg::ray_t
// result   | out | res_valid/stall | rli2d_pkg::result_t
// config   | in  | APB             | normal_x/y, anchor_x/y at 0x0..0xC
// One ray per cycle unless stalled; 38 register stages (3 front, 33 in the divider, 2 back).
// Reset clears the valid bits and loads the default line (normal 0,1.0; anchor 0,0).
// A stall freezes the whole pipe; the input is stalled only while the output is.
module ray_line_intersect_2d (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ray_valid,
  output logic                 ray_stall,
  input  rli2d_pkg::ray_t      ray,
  output logic                 res_valid,
  input  logic                 res_stall,
  output rli2d_pkg::result_t   res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [rli2d_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  // Stage map: s1 products, s2 sums, s3 sign test, div (1 check + 32 bit stages),
  // then t*dir, then output. Projection partial products form on the last delay stage.
  logic adv;
  logic signed [31:0] nx, ny, axr, ayr;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= rli2d_pkg::NORMAL_X_RST; ny <= rli2d_pkg::NORMAL_Y_RST;
      axr <= rli2d_pkg::ANCHOR_X_RST; ayr <= rli2d_pkg::ANCHOR_Y_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        rli2d_pkg::ADDR_NORMAL_X: nx  <= pwdata;
        rli2d_pkg::ADDR_NORMAL_Y: ny  <= pwdata;
        rli2d_pkg::ADDR_ANCHOR_X: axr <= pwdata;
        rli2d_pkg::ADDR_ANCHOR_Y: ayr <= pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      rli2d_pkg::ADDR_NORMAL_X: prdata = nx;
      rli2d_pkg::ADDR_NORMAL_Y: prdata = ny;
      rli2d_pkg::ADDR_ANCHOR_X: prdata = axr;
      rli2d_pkg::ADDR_ANCHOR_Y: prdata = ayr;
      default:                  prdata = '0;
    endcase
  end

  // whole pipe advances unless a finished result is held
  assign adv       = !(res_valid && res_stall);
  assign ray_stall = !adv;

  // ---- stage 1: four products (up to 33x32) ----
  logic v1;
  logic signed [63:0] pdx, pdy, pnx, pny, ox1, oy1, dx1, dy1;
  logic signed [32:0] ex, ey;
  assign ex = 33'(axr) - 33'(ray.origin_x);
  assign ey = 33'(ayr) - 33'(ray.origin_y);
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= ray_valid;
    if (adv) begin
      pdx <= rli2d_pkg::qfloor(96'(ray.dir_x) * 96'(nx));
      pdy <= rli2d_pkg::qfloor(96'(ray.dir_y) * 96'(ny));
      pnx <= rli2d_pkg::qfloor(96'(ex) * 96'(nx));
      pny <= rli2d_pkg::qfloor(96'(ey) * 96'(ny));
      ox1 <= 64'(ray.origin_x); oy1 <= 64'(ray.origin_y);
      dx1 <= 64'(ray.dir_x);    dy1 <= 64'(ray.dir_y);
    end
  end

  // ---- stage 2: sums; s needs floor(n*(o-a)), not -floor(n*(a-o)),
  // so its products are formed in stage 1 from the negated difference.
  logic v2;
  logic signed [63:0] den2, num2, s2, ox2, oy2, dx2, dy2;
  logic signed [63:0] snx, sny;
  always_ff @(posedge clk) begin
    if (adv) begin
      snx <= rli2d_pkg::qfloor(96'(-ex) * 96'(nx));
      sny <= rli2d_pkg::qfloor(96'(-ey) * 96'(ny));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      den2 <= pdx + pdy;
      num2 <= pnx + pny;
      s2   <= snx + sny;
      ox2 <= ox1; oy2 <= oy1; dx2 <= dx1; dy2 <= dy1;
    end
  end

  // ---- stage 3: hit test, magnitudes, clamp s ----
  logic v3, hit3;
  logic [rli2d_pkg::DENW-1:0] an3, bd3;
  logic signed [63:0] s3, ox3, oy3, dx3, dy3;
  logic signed [63:0] sc;
  always_comb begin
    sc = s2;
    if (s2 > (64'sd1 <<< 47)) sc = 64'sd1 <<< 47;
    if (s2 < -(64'sd1 <<< 47)) sc = -(64'sd1 <<< 47);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      hit3 <= (den2 != 0) && ((num2 == 0) || ((num2 < 0) == (den2 < 0)));
      an3  <= rli2d_pkg::DENW'(num2 < 0 ? -num2 : num2);
      bd3  <= rli2d_pkg::DENW'(den2 < 0 ? -den2 : den2);
      s3 <= sc; ox3 <= ox2; oy3 <= oy2; dx3 <= dx2; dy3 <= dy2;
    end
  end

  // ---- divider with side delay line ----
  localparam int DL = rli2d_pkg::QUOW + 1;
  logic [31:0] q;
  logic        qsat;
  rli2d_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_vld(v3),
    .a(an3), .b(bd3), .q(q), .sat(qsat)
  );

  typedef struct packed {
    logic v; logic hit;
    logic signed [63:0] s; logic signed [31:0] ox, oy, dx, dy;
  } side_t;
  side_t sd [DL+1];
  assign sd[0] = '{v: v3, hit: hit3, s: s3, ox: ox3[31:0], oy: oy3[31:0],
                   dx: dx3[31:0], dy: dy3[31:0]};
  for (genvar k = 0; k < DL; k++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) sd[k+1].v <= 1'b0;
      else if (adv) sd[k+1].v <= sd[k].v;
      if (adv) begin
        sd[k+1].hit <= sd[k].hit; sd[k+1].s <= sd[k].s;
        sd[k+1].ox <= sd[k].ox; sd[k+1].oy <= sd[k].oy;
        sd[k+1].dx <= sd[k].dx; sd[k+1].dy <= sd[k].dy;
      end
    end
  end
  side_t se;
  assign se = sd[DL];

  // s*n split in halves: s fits 49 signed bits, s = s_hi*2^24 + s_lo
  logic signed [24:0] s_hi;
  logic [23:0]        s_lo;
  logic signed [63:0] sxh, sxl, syh, syl;
  assign s_hi = sd[DL-1].s[48:24];
  assign s_lo = sd[DL-1].s[23:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      sxh <= 64'(s_hi) * 64'(nx);
      sxl <= 64'($signed({1'b0, s_lo})) * 64'(nx);
      syh <= 64'(s_hi) * 64'(ny);
      syl <= 64'($signed({1'b0, s_lo})) * 64'(ny);
    end
  end

  // ---- stage: t and products ----
  logic vt, hitt, ovt;
  logic [30:0] tt;
  logic signed [63:0] phx, phy, psx, psy;
  logic signed [31:0] oxt, oyt;
  logic [30:0] tsel;
  assign tsel = qsat ? 31'h7FFF_FFFF : q[30:0];
  always_ff @(posedge clk) begin
    if (rst) vt <= 1'b0;
    else if (adv) vt <= se.v;
    if (adv) begin
      hitt <= se.hit;
      ovt  <= se.hit && qsat;
      tt   <= se.hit ? tsel : '0;
      phx  <= rli2d_pkg::qfloor(96'($signed({1'b0, tsel})) * 96'(se.dx));
      phy  <= rli2d_pkg::qfloor(96'($signed({1'b0, tsel})) * 96'(se.dy));
      psx  <= rli2d_pkg::qfloor((96'(sxh) <<< 24) + 96'(sxl));
      psy  <= rli2d_pkg::qfloor((96'(syh) <<< 24) + 96'(syl));
      oxt <= se.ox; oyt <= se.oy;
    end
  end

  // ---- output register ----
  logic signed [63:0] hx, hy, qx, qy;
  assign hx = 64'(oxt) + phx;
  assign hy = 64'(oyt) + phy;
  assign qx = 64'(oxt) - psx;
  assign qy = 64'(oyt) - psy;
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (adv) res_valid <= vt;
    if (adv) begin
      res.hit      <= hitt;
      res.distance <= tt;
      res.hit_x    <= hitt ? rli2d_pkg::sat32(hx) : '0;
      res.hit_y    <= hitt ? rli2d_pkg::sat32(hy) : '0;
      res.near_x   <= rli2d_pkg::sat32(qx);
      res.near_y   <= rli2d_pkg::sat32(qy);
      res.overflow <= ovt || (hitt && (rli2d_pkg::ovf32(hx) || rli2d_pkg::ovf32(hy)))
                      || rli2d_pkg::ovf32(qx) || rli2d_pkg::ovf32(qy);
    end
  end

  logic unused;
  assign unused = ^{se.s, ox3[63:32], oy3[63:32], dx3[63:32], dy3[63:32], q[31]};
endmodule

>>> hw/rtl/rli2d_chk.sv
module rli2d_chk (
  input logic clk,
  input logic rst,
  input logic ray_valid,
  input logic ray_stall,
  input logic res_valid,
  input logic res_stall,
  input rli2d_pkg::result_t res
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res)) else $error("result dropped");
  a_nohit: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.hit |-> res.distance == 0) else $error("distance without hit");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    ray_stall |-> res_valid && res_stall) else $error("spurious stall");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !res_valid) else $error("valid in reset");
endmodule

bind ray_line_intersect_2d rli2d_chk u_chk (.*);
